FILE: src/kslb_pkg.sv
// package for the keyboard scan line buffer: sizes, codes, types and key maps
package kslb_pkg;

  localparam int unsigned QUEUE_DEPTH = 32;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CHAR_W      = 7;
  localparam int unsigned LEN_W       = 6;
  localparam int unsigned LINE_W      = 8;

  localparam logic [LEN_W-1:0]  LINE_CAP  = LEN_W'(32);
  localparam logic [CHAR_W-1:0] CH_NUL    = 7'h00;
  localparam logic [CHAR_W-1:0] CH_LF     = 7'h0a;
  localparam logic [CHAR_W-1:0] CH_CR     = 7'h0d;
  localparam logic [LINE_W-1:0] LINE_MAX  = 8'd255;

  localparam logic [CHAR_W-1:0] LEFT_SHIFT_RST  = 7'd42;
  localparam logic [CHAR_W-1:0] RIGHT_SHIFT_RST = 7'd54;

  typedef enum logic [1:0] {
    KIND_SCAN = 2'd0,
    KIND_GETC = 2'd1,
    KIND_LINE = 2'd2,
    KIND_NONE = 2'd3
  } kslb_kind_e;

  typedef enum logic [1:0] {
    CFG_LEFT_SHIFT  = 2'd0,
    CFG_RIGHT_SHIFT = 2'd1
  } kslb_cfg_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_LINE = 1'b1
  } kslb_state_e;

  // queue request from control
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CHAR_W-1:0] ch;
  } kslb_qcmd_t;

  // queue status back to control
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [CHAR_W-1:0] head;
  } kslb_qstat_t;

  function automatic logic [CHAR_W-1:0] plain_char(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] r;
    unique case (code)
      7'd2:  r = 7'h31;
      7'd3:  r = 7'h32;
      7'd4:  r = 7'h33;
      7'd5:  r = 7'h34;
      7'd6:  r = 7'h35;
      7'd7:  r = 7'h36;
      7'd8:  r = 7'h37;
      7'd9:  r = 7'h38;
      7'd10: r = 7'h39;
      7'd11: r = 7'h30;
      7'd12: r = 7'h2d;
      7'd13: r = 7'h3d;
      7'd14: r = 7'd8;
      7'd16: r = 7'h71;
      7'd17: r = 7'h77;
      7'd18: r = 7'h65;
      7'd19: r = 7'h72;
      7'd20: r = 7'h74;
      7'd21: r = 7'h79;
      7'd22: r = 7'h75;
      7'd23: r = 7'h69;
      7'd24: r = 7'h6f;
      7'd25: r = 7'h70;
      7'd26: r = 7'h5b;
      7'd27: r = 7'h5d;
      7'd28: r = 7'd13;
      7'd29: r = 7'd14;
      7'd30: r = 7'h61;
      7'd31: r = 7'h73;
      7'd32: r = 7'h64;
      7'd33: r = 7'h66;
      7'd34: r = 7'h67;
      7'd35: r = 7'h68;
      7'd36: r = 7'h6a;
      7'd37: r = 7'h6b;
      7'd38: r = 7'h6c;
      7'd39: r = 7'h3b;
      7'd40: r = 7'h27;
      7'd41: r = 7'h60;
      7'd43: r = 7'h5c;
      7'd44: r = 7'h7a;
      7'd45: r = 7'h78;
      7'd46: r = 7'h63;
      7'd47: r = 7'h76;
      7'd48: r = 7'h62;
      7'd49: r = 7'h6e;
      7'd50: r = 7'h6d;
      7'd51: r = 7'h2c;
      7'd52: r = 7'h2e;
      7'd53: r = 7'h2f;
      7'd57: r = 7'h20;
      7'd71: r = 7'd2;
      7'd72: r = 7'd17;
      7'd73: r = 7'd3;
      7'd75: r = 7'd13;
      7'd77: r = 7'd14;
      7'd79: r = 7'd4;
      7'd80: r = 7'd12;
      7'd81: r = 7'd5;
      7'd82: r = 7'd1;
      7'd83: r = 7'd127;
      7'd90: r = 7'd6;
      default: r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] shifted_char(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] p;
    logic [CHAR_W-1:0] r;
    p = plain_char(code);
    unique case (code)
      7'd2:  r = 7'h21;
      7'd3:  r = 7'h40;
      7'd4:  r = 7'h23;
      7'd5:  r = 7'h24;
      7'd6:  r = 7'h25;
      7'd7:  r = 7'h5e;
      7'd8:  r = 7'h26;
      7'd9:  r = 7'h2a;
      7'd10: r = 7'h28;
      7'd11: r = 7'h29;
      7'd12: r = 7'h5f;
      7'd13: r = 7'h2b;
      7'd26: r = 7'h7b;
      7'd27: r = 7'h7d;
      7'd39: r = 7'h3a;
      7'd40: r = 7'h22;
      7'd41: r = 7'h7e;
      7'd43: r = 7'h7c;
      7'd51: r = 7'h3c;
      7'd52: r = 7'h3e;
      7'd53: r = 7'h3f;
      default: begin
        // lower-case letters go to upper case
        if (p >= 7'h61 && p <= 7'h7a) begin
          r = p - 7'h20;
        end else begin
          r = p;
        end
      end
    endcase
    return r;
  endfunction

endpackage

FILE: src/keyboard_scan_line_buffer.sv
// top level: scan code translation, control and result register of the line buffer
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid_i/tready_o     tdata scan_code, max_length; tuser kind, data_ready
// m_axis    out  m_axis_tvalid_o/tready_i     tdata char_out; tuser ok; tlast last
// cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// a get-character request or a character scan puts its result in the output register next cycle
// get-line gives n+1 results, one per cycle while m_axis is ready, as the chain shifts one cell
// reset clears control, counters and shift codes; the queue cells hold no reset value
// a request is taken only in idle with the output register free or being drained
module keyboard_scan_line_buffer
  import kslb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [15:0]       s_axis_tdata_i,  // scan_code[7:0], max_length[13:8], zero fill
  input  logic [2:0]        s_axis_tuser_i,  // kind[1:0], data_ready[2]
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [7:0]        m_axis_tdata_o,  // char_out[6:0], zero fill
  output logic [0:0]        m_axis_tuser_o,  // ok[0]
  output logic              m_axis_tlast_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [CHAR_W-1:0] cfg_data_i
);

  kslb_state_e       state_q, state_d;
  logic [CHAR_W-1:0] left_q, left_d;
  logic [CHAR_W-1:0] right_q, right_d;
  logic              shift_q, shift_d;
  logic [LINE_W-1:0] line_q, line_d;
  logic [LEN_W-1:0]  n_q, n_d;
  logic [LEN_W-1:0]  lim_q, lim_d;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_ok_q, out_ok_d;
  logic              out_last_q, out_last_d;

  kslb_qcmd_t        qcmd;
  kslb_qstat_t       qstat;

  logic              out_free;
  logic              in_accept;
  kslb_kind_e        kind;
  logic              data_ready;
  logic [7:0]        scan_code;
  logic [LEN_W-1:0]  max_length;
  logic [CHAR_W-1:0] key_char;
  logic              head_term;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;
  assign kind            = kslb_kind_e'(s_axis_tuser_i[1:0]);
  assign data_ready      = s_axis_tuser_i[2];
  assign scan_code       = s_axis_tdata_i[7:0];
  assign max_length      = s_axis_tdata_i[13:8];
  assign key_char        = shift_q ? shifted_char(scan_code[6:0]) : plain_char(scan_code[6:0]);
  assign head_term       = (qstat.head == CH_CR) || (qstat.head == CH_LF) ||
                           (qstat.head == CH_NUL);

  assign cfg_ready_o = 1'b1;

  always_comb begin
    left_d  = left_q;
    right_d = right_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LEFT_SHIFT:  left_d  = cfg_data_i;
        CFG_RIGHT_SHIFT: right_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  kslb_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (qcmd),
    .stat_o(qstat)
  );

  always_comb begin
    state_d     = state_q;
    shift_d     = shift_q;
    line_d      = line_q;
    n_d         = n_q;
    lim_d       = lim_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_char_d  = out_char_q;
    out_ok_d    = out_ok_q;
    out_last_d  = out_last_q;
    qcmd.push   = 1'b0;
    qcmd.pop    = 1'b0;
    qcmd.ch     = key_char;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (kind)
            KIND_SCAN: begin
              if (data_ready && !scan_code[7]) begin
                if (scan_code[6:0] == left_q || scan_code[6:0] == right_q) begin
                  shift_d = 1'b1;
                end else begin
                  shift_d     = 1'b0;
                  out_valid_d = 1'b1;
                  out_char_d  = key_char;
                  out_ok_d    = 1'b1;
                  out_last_d  = 1'b1;
                  qcmd.push   = 1'b1;
                  if (key_char == CH_CR && line_q != LINE_MAX) begin
                    line_d = line_q + LINE_W'(1);
                  end
                end
              end
            end
            KIND_GETC: begin
              out_valid_d = 1'b1;
              out_last_d  = 1'b1;
              if (qstat.count == '0) begin
                out_char_d = CH_NUL;
                out_ok_d   = 1'b0;
              end else begin
                out_char_d = qstat.head;
                out_ok_d   = 1'b1;
                qcmd.pop   = 1'b1;
              end
            end
            KIND_LINE: begin
              if (line_q == '0) begin
                out_valid_d = 1'b1;
                out_char_d  = CH_NUL;
                out_ok_d    = 1'b0;
                out_last_d  = 1'b1;
              end else begin
                state_d = ST_LINE;
                n_d     = '0;
                lim_d   = (max_length > LINE_CAP) ? LINE_CAP : max_length;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LINE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_ok_d    = 1'b1;
          if (qstat.count != '0 && n_q < lim_q && !head_term) begin
            out_char_d = qstat.head;
            out_last_d = 1'b0;
            qcmd.pop   = 1'b1;
            n_d        = n_q + LEN_W'(1);
          end else begin
            // terminator, and the stopping character leaves with it
            out_char_d = CH_NUL;
            out_last_d = 1'b1;
            qcmd.pop   = (qstat.count != '0);
            line_d     = line_q - LINE_W'(1);
            state_d    = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      left_q      <= LEFT_SHIFT_RST;
      right_q     <= RIGHT_SHIFT_RST;
      shift_q     <= 1'b0;
      line_q      <= '0;
      n_q         <= '0;
      lim_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      left_q      <= left_d;
      right_q     <= right_d;
      shift_q     <= shift_d;
      line_q      <= line_d;
      n_q         <= n_d;
      lim_q       <= lim_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_ok_q   <= out_ok_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tuser_o  = out_ok_q;
  assign m_axis_tlast_o  = out_last_q;

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcmd.pop |-> (qstat.count != '0))
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_line_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINE) |-> !s_axis_tready_o)
    else $error("request taken during get-line");

  a_line_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LINE && state_d == ST_IDLE) |=> (m_axis_tvalid_o && m_axis_tlast_o))
    else $error("get-line ended without a last result");

endmodule

FILE: src/kslb_cell.sv
// one character cell of the queue chain
module kslb_cell
  import kslb_pkg::*;
(
  input  logic              clk_i,
  input  logic              load_i,
  input  logic              shift_i,
  input  logic [CHAR_W-1:0] nbr_i,
  input  logic [CHAR_W-1:0] new_i,
  output logic [CHAR_W-1:0] char_o
);

  logic [CHAR_W-1:0] char_q;
  logic [CHAR_W-1:0] char_d;

  always_comb begin
    char_d = char_q;
    if (load_i) begin
      char_d = new_i;
    end else if (shift_i) begin
      char_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign char_o = char_q;

endmodule

FILE: src/kslb_queue.sv
// character queue as a chain of cells, oldest character in cell zero
module kslb_queue
  import kslb_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  kslb_qcmd_t  cmd_i,
  output kslb_qstat_t stat_o
);

  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic              full;
  logic              shift_all;
  logic [CHAR_W-1:0] cell_char [QUEUE_DEPTH];

  assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
  // a push into a full queue drops the oldest by shifting everything down
  assign shift_all = cmd_i.pop || (cmd_i.push && full);

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic              load;
    logic [CHAR_W-1:0] nbr;

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign load = cmd_i.push && (full || count_q == CNT_W'(i));
      assign nbr  = CH_NUL;
    end else begin : g_body
      assign load = cmd_i.push && !full && (count_q == CNT_W'(i));
      assign nbr  = cell_char[i+1];
    end

    kslb_cell u_cell (
      .clk_i  (clk_i),
      .load_i (load),
      .shift_i(shift_all),
      .nbr_i  (nbr),
      .new_i  (cmd_i.ch),
      .char_o (cell_char[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.push && !full) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign stat_o.count = count_q;
  assign stat_o.head  = cell_char[0];

endmodule

FILE: bench/tb.sv
// testbench for the keyboard scan line buffer: stimulus, result checking and run control
`timescale 1ns / 1ps

module tb
  import kslb_pkg::*;
;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              ok;
    logic              last;
  } char_result_t;

  // tracks what the buffer should hold and queues the characters it should send back
  class line_buffer_board;
    logic [CHAR_W-1:0] plain_keys [128];
    logic [CHAR_W-1:0] shifted_keys [128];
    logic [CHAR_W-1:0] left_shift;
    logic [CHAR_W-1:0] right_shift;
    logic [CHAR_W-1:0] held_chars [$];
    logic [LINE_W-1:0] line_total;
    logic              shift_held;
    char_result_t      pending_chars [$];
    int                errors;
    int                checked;
    int                longest_line;
    int                dropped;
    int                line_peak;

    function new();
      byte unsigned ctrl_code [14] = '{14, 28, 29, 71, 72, 73, 75, 77, 79, 80, 81, 82, 83, 90};
      byte unsigned ctrl_char [14] = '{8, 13, 14, 2, 17, 3, 13, 14, 4, 12, 5, 1, 127, 6};
      for (int i = 0; i < 128; i++) begin
        plain_keys[i]   = CH_NUL;
        shifted_keys[i] = CH_NUL;
      end
      put_row(2, "1234567890-=", "!@#$%^&*()_+");
      put_row(16, "qwertyuiop[]", "QWERTYUIOP{}");
      put_row(30, "asdfghjkl;'", "ASDFGHJKL:\"");
      put_row(43, "\\zxcvbnm,./", "|ZXCVBNM<>?");
      put_row(57, " ", " ");
      plain_keys[41]   = 7'h60;
      shifted_keys[41] = 7'h7e;
      for (int i = 0; i < 14; i++) begin
        plain_keys[ctrl_code[i]]   = ctrl_char[i][CHAR_W-1:0];
        shifted_keys[ctrl_code[i]] = ctrl_char[i][CHAR_W-1:0];
      end
      left_shift  = LEFT_SHIFT_RST;
      right_shift = RIGHT_SHIFT_RST;
      line_total  = '0;
      shift_held  = 1'b0;
    endfunction

    function void put_row(int first, string plain, string shifted);
      for (int i = 0; i < plain.len(); i++) begin
        plain_keys[first + i]   = CHAR_W'(plain[i]);
        shifted_keys[first + i] = CHAR_W'(shifted[i]);
      end
    endfunction

    // returns 1 when the request changes state or produces characters
    function bit note_request(kslb_kind_e k, logic dr, logic [7:0] code, logic [LEN_W-1:0] len);
      logic [CHAR_W-1:0] ch;
      int                n;
      int                lim;
      case (k)
        KIND_SCAN: begin
          if (!dr || code[7]) return 1'b0;
          if (code[6:0] == left_shift || code[6:0] == right_shift) begin
            shift_held = 1'b1;
            return 1'b1;
          end
          ch = shift_held ? shifted_keys[code[6:0]] : plain_keys[code[6:0]];
          shift_held = 1'b0;
          pending_chars.push_back(char_result_t'{ch, 1'b1, 1'b1});
          if (ch == CH_CR && line_total < LINE_MAX) line_total++;
          if (line_total > line_peak) line_peak = line_total;
          // full queue loses its oldest character
          if (held_chars.size() == QUEUE_DEPTH) begin
            void'(held_chars.pop_front());
            dropped++;
          end
          held_chars.push_back(ch);
        end
        KIND_GETC: begin
          if (held_chars.size() == 0) begin
            pending_chars.push_back(char_result_t'{CH_NUL, 1'b0, 1'b1});
          end else begin
            pending_chars.push_back(char_result_t'{held_chars.pop_front(), 1'b1, 1'b1});
          end
        end
        KIND_LINE: begin
          if (line_total == 0) begin
            pending_chars.push_back(char_result_t'{CH_NUL, 1'b0, 1'b1});
            return 1'b1;
          end
          lim = (len > LINE_CAP) ? LINE_CAP : len;
          n = 0;
          while (n < held_chars.size() && n < lim) begin
            ch = held_chars[n];
            if (ch == CH_CR || ch == CH_LF || ch == CH_NUL) break;
            pending_chars.push_back(char_result_t'{ch, 1'b1, 1'b0});
            n++;
          end
          pending_chars.push_back(char_result_t'{CH_NUL, 1'b1, 1'b1});
          if (n > longest_line) longest_line = n;
          // the terminator slot goes too, bounded by what is held
          for (int i = 0; i <= n && held_chars.size() > 0; i++) void'(held_chars.pop_front());
          line_total--;
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    task check_char(logic [CHAR_W-1:0] ch, logic ok, logic last);
      char_result_t want;
      checked++;
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("char 0x%02h ok %0b last %0b with nothing pending", ch, ok, last));
        return;
      end
      want = pending_chars.pop_front();
      if (ch !== want.ch)
        report_mismatch($sformatf("char 0x%02h, wanted 0x%02h", ch, want.ch));
      if (ok !== want.ok)
        report_mismatch($sformatf("ok %0b, wanted %0b (char 0x%02h)", ok, want.ok, want.ch));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, wanted %0b (char 0x%02h)", last, want.last, want.ch));
    endtask

    task report_mismatch(string msg);
      errors++;
      $display("%0t ns: result %0d: %s", $realtime, checked, msg);
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [15:0]         s_axis_tdata_i;  // scan_code[7:0], max_length[13:8], zero fill
  logic [2:0]          s_axis_tuser_i;  // kind[1:0], data_ready[2]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [7:0]          m_axis_tdata_o;  // char_out[6:0], zero fill
  logic [0:0]          m_axis_tuser_o;  // ok[0]
  logic                m_axis_tlast_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i;
  logic [CHAR_W-1:0]   cfg_data_i;

  line_buffer_board sb = new();

  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold_left;
  int requests;
  int acted;
  int settings;

  logic [6:0] ctrl_keys [13] = '{14, 29, 71, 72, 73, 75, 77, 79, 80, 81, 82, 83, 90};

  keyboard_scan_line_buffer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #20_000_000;
    $display("keyboard_scan_line_buffer: mismatch");
    $finish;
  end

  // receiver: random stalls plus an optional long hold-off
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // outputs are stable at the falling edge; a match there is taken at the next rising edge
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && m_axis_tvalid_o === 1'b1 && m_axis_tready_i === 1'b1)
        sb.check_char(m_axis_tdata_o[CHAR_W-1:0], m_axis_tuser_o[0], m_axis_tlast_o);
    end
  end

  task automatic send_item(input kslb_kind_e k, input logic dr, input logic [7:0] code,
                           input logic [LEN_W-1:0] len);
    bit taken;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {2'b00, len, code};
    s_axis_tuser_i  <= {dr, k};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end
    requests++;
    if (sb.note_request(k, dr, code, len)) acted++;
  endtask

  task automatic write_reg(input kslb_cfg_e idx, input logic [CHAR_W-1:0] val);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end
    if (idx == CFG_LEFT_SHIFT) sb.left_shift = val;
    else sb.right_shift = val;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // no request in flight and every expected character back
  task automatic quiesce();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_chars.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic [6:0] pick_key();
    int          r;
    logic [6:0]  c;
    r = $urandom_range(99);
    if (r < 80) begin
      do c = 7'($urandom_range(2, 57)); while (sb.plain_keys[c] == CH_NUL || c == 7'd28);
    end else if (r < 90) begin
      c = ctrl_keys[$urandom_range(12)];
    end else begin
      c = 7'($urandom_range(127));
    end
    return c;
  endfunction

  task automatic scan_key(input logic [7:0] code);
    send_item(KIND_SCAN, 1'b1, code, LEN_W'($urandom_range(63)));
  endtask

  task automatic get_line();
    logic [LEN_W-1:0] len;
    len = ($urandom_range(99) < 15) ? LEN_W'($urandom_range(33, 63)) :
                                      LEN_W'($urandom_range(0, 34));
    send_item(KIND_LINE, 1'($urandom_range(1)), 8'($urandom_range(255)), len);
  endtask

  // one typed line: optional shifts, releases and noise, usually closed by a return key, often followed by reads
  task automatic type_line();
    int         keys;
    int         r;
    logic [6:0] code;
    keys = ($urandom_range(9) == 0) ? $urandom_range(30, 40) : $urandom_range(0, 12);
    repeat (keys) begin
      if ($urandom_range(99) < 15)
        scan_key({1'b0, ($urandom_range(1) ? sb.left_shift : sb.right_shift)});
      code = pick_key();
      scan_key({1'b0, code});
      if ($urandom_range(99) < 30) scan_key({1'b1, code});
      r = $urandom_range(99);
      if (r < 2) begin
        send_item(KIND_NONE, 1'($urandom_range(1)), 8'($urandom_range(255)),
                  LEN_W'($urandom_range(63)));
      end else if (r < 4) begin
        send_item(KIND_SCAN, 1'b0, 8'($urandom_range(255)), LEN_W'($urandom_range(63)));
      end else if (r < 6) begin
        scan_key(8'($urandom_range(255)));
      end
    end
    if ($urandom_range(99) < 85) scan_key($urandom_range(1) ? 8'd28 : 8'd75);
    r = $urandom_range(99);
    if (r < 55) begin
      get_line();
    end else if (r < 75) begin
      repeat ($urandom_range(1, 4))
        send_item(KIND_GETC, 1'($urandom_range(1)), 8'($urandom_range(255)),
                  LEN_W'($urandom_range(63)));
    end
  endtask

  initial begin
    int mark;
    int extra;
    int r;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_LEFT_SHIFT;
    cfg_data_i      = '0;
    tx_idle_pct     = 0;
    rx_stall_pct    = 0;
    rx_hold_left    = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty reads, ignored items, shifts, unmapped keys, short and empty lines
    send_item(KIND_GETC, 1'b0, 8'h00, 6'd0);
    send_item(KIND_LINE, 1'b1, 8'hff, 6'd63);
    send_item(KIND_NONE, 1'b1, 8'd30, 6'd5);
    send_item(KIND_SCAN, 1'b0, 8'd30, 6'd0);
    scan_key(8'h9e);
    scan_key(8'hff);
    scan_key(8'd30);
    scan_key(8'd42);
    scan_key(8'd30);
    scan_key(8'd54);
    scan_key(8'd2);
    scan_key(8'd0);
    scan_key(8'd127);
    scan_key(8'd83);
    scan_key(8'd28);
    send_item(KIND_LINE, 1'b0, 8'h00, 6'd63);
    scan_key(8'd28);
    send_item(KIND_GETC, 1'b1, 8'hff, 6'd63);
    send_item(KIND_LINE, 1'b1, 8'h00, 6'd0);
    send_item(KIND_GETC, 1'b0, 8'h00, 6'd0);
    scan_key(8'd75);
    repeat (3) send_item(KIND_GETC, 1'b1, 8'h55, 6'd21);
    send_item(KIND_LINE, 1'b0, 8'haa, 6'd42);

    for (int phase = 0; phase < 4; phase++) begin
      quiesce();
      case (phase)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          rx_hold_left = 300;  // block backs up and refuses requests
        end
        1: begin
          write_reg(CFG_LEFT_SHIFT, 7'd0);
          write_reg(CFG_RIGHT_SHIFT, 7'd127);
          tx_idle_pct  = 66;
          rx_stall_pct = 0;
        end
        2: begin
          write_reg(CFG_LEFT_SHIFT, 7'($urandom_range(127)));
          write_reg(CFG_RIGHT_SHIFT, 7'($urandom_range(127)));
          tx_idle_pct  = 0;
          rx_stall_pct = 66;
        end
        default: begin
          write_reg(CFG_RIGHT_SHIFT, RIGHT_SHIFT_RST);
          write_reg(CFG_LEFT_SHIFT, LEFT_SHIFT_RST);
          tx_idle_pct  = 6;
          rx_stall_pct = 6;
        end
      endcase
      settings++;
      // a full queue of plain letters behind a pending line gives the longest run
      if (phase == 0) begin
        scan_key(8'd28);
        repeat (34) scan_key(8'($urandom_range(16, 25)));
      end
      get_line();
      send_item(KIND_LINE, 1'b1, 8'($urandom_range(255)), 6'd32);
      mark = acted;
      while (acted - mark < 12) type_line();
    end

    // return-key storm until the line count sits at its ceiling
    extra = 0;
    while (extra < 12) begin
      if (sb.line_total == LINE_MAX) extra++;
      r = $urandom_range(99);
      if (r < 95) begin
        scan_key($urandom_range(1) ? 8'd28 : 8'd75);
      end else if (r < 98) begin
        send_item(KIND_GETC, 1'($urandom_range(1)), 8'($urandom_range(255)),
                  LEN_W'($urandom_range(63)));
      end else begin
        scan_key({1'b0, pick_key()});
      end
    end
    repeat (4) get_line();

    s_axis_tvalid_i <= 1'b0;
    while (sb.pending_chars.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("run covered %0d requests (%0d acted on), %0d results over %0d shift settings",
             requests, acted, sb.checked, settings + 1);
    $display("longest line %0d chars, %0d overflow drops, line count peak %0d",
             sb.longest_line, sb.dropped, sb.line_peak);
    if (sb.errors == 0) begin
      $display("keyboard_scan_line_buffer: match");
    end else begin
      $display("keyboard_scan_line_buffer: mismatch");
    end
    $finish;
  end

endmodule
